/* sv/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helper functions for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_LEN          = 24;
  localparam int TAB_IDX_W        = 5;
  localparam int CW               = 36;   // cordic datapath width
  localparam int DIV_W            = 64;   // divider dividend width

  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 36'sd652032874;

  // configuration register indexes
  localparam logic REG_TICK_TO_RADIAN = 1'b0;
  localparam logic REG_RADIUS         = 1'b1;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_ctl_t;

  // arctangent of 2^-i as 32-bit binary angle
  function automatic logic [31:0] atan_of(input logic [TAB_IDX_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/ddo_cordic.sv */
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ddo_pkg::cordic_ctl_t            ctl,
  input  logic signed [ddo_pkg::CW-1:0]   x0,
  input  logic signed [ddo_pkg::CW-1:0]   y0,
  input  logic        [31:0]              z0,
  output logic                            done,
  output logic signed [ddo_pkg::CW-1:0]   x_out,
  output logic signed [ddo_pkg::CW-1:0]   y_out,
  output logic        [31:0]              z_out
);

  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy;
  logic             mode;
  logic [CNT_W-1:0] cnt;
  logic signed [ddo_pkg::CW-1:0] xs, ys;
  logic [31:0]      ang;
  logic             ccw;

  assign xs  = x_out >>> cnt;
  assign ys  = y_out >>> cnt;
  assign ang = ddo_pkg::atan_of(ddo_pkg::TAB_IDX_W'(cnt));
  // rotation: drive z to zero; vectoring: drive y to zero
  assign ccw = mode ? ~z_out[31] : y_out[ddo_pkg::CW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      mode <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        mode  <= ctl.rotate;
        cnt   <= '0;
        x_out <= x0;
        y_out <= y0;
        z_out <= z0;
      end else if (busy) begin
        if (ccw) begin
          x_out <= x_out - ys;
          y_out <= y_out + xs;
          z_out <= z_out - ang;
        end else begin
          x_out <= x_out + ys;
          y_out <= y_out - xs;
          z_out <= z_out + ang;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* sv/ddo_div.sv */
// ----------------------------------------------------------------------------
// ddo_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ddo_pkg::DIV_W-1:0] num,
  input  logic [31:0]               den,
  output logic                      done,
  output logic [ddo_pkg::DIV_W-1:0] quot
);

  localparam int CYCLES = ddo_pkg::DIV_W / 2;
  localparam int CNT_W  = $clog2(CYCLES);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [31:0]               rem;
  logic [31:0]               r_t;
  logic [ddo_pkg::DIV_W-1:0] q_t;
  logic [32:0]               r_sh;

  always_comb begin
    r_t  = rem;
    q_t  = quot;
    r_sh = '0;
    for (int k = 0; k < 2; k++) begin
      r_sh = {r_t, q_t[ddo_pkg::DIV_W-1]};
      q_t  = {q_t[ddo_pkg::DIV_W-2:0], 1'b0};
      if (r_sh >= {1'b0, den}) begin
        r_t    = 32'(r_sh - {1'b0, den});
        q_t[0] = 1'b1;
      end else begin
        r_t = r_sh[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= num;
        rem  <= '0;
      end else if (busy) begin
        quot <= q_t;
        rem  <= r_t;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* sv/diff_drive_odometry.sv */
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive odometry with CORDIC yaw, midpoint integration and speeds.
// ----------------------------------------------------------------------------
// One update is taken at a time: s_tready is high only while the block is
// idle, and the result then waits in the output register until taken. An
// odometry update runs two CORDIC passes (yaw, then cosine and sine),
// eleven passes through the shared multiplier and four divisions in the
// two-bit-per-cycle divider. A degenerate quaternion skips the yaw pass. A
// pose reset or a zero step time offers its result on the cycle after the
// transfer. Angles are 16-bit binary angles that wrap; positions and speeds
// saturate to 32 bits.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // left_ticks, right_ticks, quat_w, quat_x, quat_y, quat_z, step_ms
  input  logic [111:0] s_tdata,
  // kind
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, heading, linear_speed, turn_rate, left_wheel_speed,
  // right_wheel_speed
  output logic [207:0] m_tdata,
  // valid_res
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_Q0     = 5'd1;
  localparam logic [4:0] ST_Q1     = 5'd2;
  localparam logic [4:0] ST_Q2     = 5'd3;
  localparam logic [4:0] ST_Q3     = 5'd4;
  localparam logic [4:0] ST_VEC_GO = 5'd5;
  localparam logic [4:0] ST_VEC_W  = 5'd6;
  localparam logic [4:0] ST_T0     = 5'd7;
  localparam logic [4:0] ST_T1     = 5'd8;
  localparam logic [4:0] ST_T2     = 5'd9;
  localparam logic [4:0] ST_ROT_GO = 5'd10;
  localparam logic [4:0] ST_ROT_W  = 5'd11;
  localparam logic [4:0] ST_PX     = 5'd12;
  localparam logic [4:0] ST_PY     = 5'd13;
  localparam logic [4:0] ST_PH     = 5'd14;
  localparam logic [4:0] ST_WL     = 5'd15;
  localparam logic [4:0] ST_WR     = 5'd16;
  localparam logic [4:0] ST_DV_GO  = 5'd17;
  localparam logic [4:0] ST_DV_W   = 5'd18;
  localparam logic [4:0] ST_OUT    = 5'd19;

  localparam logic [1:0] DIV_LIN   = 2'd0;
  localparam logic [1:0] DIV_TURN  = 2'd1;
  localparam logic [1:0] DIV_LEFT  = 2'd2;
  localparam logic [1:0] DIV_RIGHT = 2'd3;

  localparam int CW = ddo_pkg::CW;

  logic [4:0]  state;

  // configuration
  logic [31:0] tick_to_radian;
  logic [15:0] radius_q16;

  // latched item
  logic signed [15:0] lt, rt, qw, qx, qy, qz;
  logic [15:0]        step;

  // pose state
  logic signed [31:0] x_position, y_position;
  logic [15:0]        heading_angle, previous_yaw;

  // working registers
  logic signed [33:0] acc_y, acc_x;
  logic [47:0]        acc_m;
  logic [63:0]        acc_d;
  logic signed [32:0] ds;
  logic [15:0]        yaw;
  logic [15:0]        dth;
  logic               flip;
  logic signed [31:0] c_val, s_val;
  logic signed [65:0] prod;
  logic signed [48:0] wl_p, wr_p;
  logic [1:0]         dsel;

  // result registers
  logic               res_valid;
  logic signed [31:0] lin_speed, turn_rate, lw_speed, rw_speed;

  // shared multiplier
  logic signed [33:0] m_a, m_b;
  logic signed [67:0] m_p;

  logic signed [16:0] sum;
  logic [16:0]        sum_mag;
  logic [31:0]        dmag;
  logic [15:0]        dth_c;
  logic [31:0]        mid;
  logic               flip_c;
  logic               vec_neg;
  logic               vec_zero;
  logic signed [65:0] prod_r;
  logic signed [63:0] pos_sum;

  ddo_pkg::cordic_ctl_t   cctl;
  logic signed [CW-1:0]   cx0, cy0, cx, cy;
  logic [31:0]            cz0, cz;
  logic                   c_done;

  logic signed [63:0] nv, nk;
  logic               nneg;
  logic [63:0]        nmag, dnum, dquot;
  logic [31:0]        dden;
  logic               d_start, d_done;
  logic signed [63:0] dres;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tuser  = res_valid;
  assign m_tdata  = {rw_speed, lw_speed, turn_rate, lin_speed, heading_angle,
                     y_position, x_position};

  assign sum     = 17'(lt) + 17'(rt);
  assign sum_mag = sum[16] ? 17'(-sum) : 17'(sum);
  assign dmag    = 32'((65'(acc_d) + 65'h100000000) >> 33);

  // midpoint angle and half-plane fold for the rotation pass
  assign dth_c  = yaw - previous_yaw;
  assign mid    = {heading_angle, 16'h0} + {dth_c[15], dth_c, 15'h0};
  assign flip_c = ((mid + 32'h40000000) >> 31) != 32'd0;

  assign vec_neg  = acc_x[33];
  assign vec_zero = (acc_x == '0) && (acc_y == '0);

  assign m_p = m_a * m_b;

  always_comb begin
    m_a = '0;
    m_b = '0;
    case (state)
      ST_Q0: begin m_a = 34'(qx); m_b = 34'(qy); end
      ST_Q1: begin m_a = 34'(qw); m_b = 34'(qz); end
      ST_Q2: begin m_a = 34'(qy); m_b = 34'(qy); end
      ST_Q3: begin m_a = 34'(qz); m_b = 34'(qz); end
      ST_T0: begin
        m_a = $signed({2'b00, tick_to_radian});
        m_b = $signed({18'h0, radius_q16});
      end
      ST_T1: begin
        m_a = $signed({10'h0, acc_m[23:0]});
        m_b = $signed({17'h0, sum_mag});
      end
      ST_T2: begin
        m_a = $signed({10'h0, acc_m[47:24]});
        m_b = $signed({17'h0, sum_mag});
      end
      ST_PX: begin m_a = 34'(ds); m_b = 34'(c_val); end
      ST_PY: begin m_a = 34'(ds); m_b = 34'(s_val); end
      ST_WL: begin m_a = $signed({2'b00, tick_to_radian}); m_b = 34'(lt); end
      ST_WR: begin m_a = $signed({2'b00, tick_to_radian}); m_b = 34'(rt); end
      default: begin m_a = '0; m_b = '0; end
    endcase
  end

  // cordic control
  always_comb begin
    cctl.start  = ((state == ST_VEC_GO) && !vec_zero) || (state == ST_ROT_GO);
    cctl.rotate = (state == ST_ROT_GO);
    if (state == ST_ROT_GO) begin
      cx0 = ddo_pkg::INV_GAIN_Q30;
      cy0 = '0;
      cz0 = flip_c ? mid + 32'h80000000 : mid;
    end else begin
      cx0 = vec_neg ? -CW'(acc_x) : CW'(acc_x);
      cy0 = vec_neg ? -CW'(acc_y) : CW'(acc_y);
      cz0 = vec_neg ? 32'h80000000 : 32'h0;
    end
  end

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cctl),
    .x0    (cx0),
    .y0    (cy0),
    .z0    (cz0),
    .done  (c_done),
    .x_out (cx),
    .y_out (cy),
    .z_out (cz)
  );

  // position step rounded half up
  assign prod_r  = (prod + (66'sd1 <<< 29)) >>> 30;
  assign pos_sum = (state == ST_PY) ? 64'(x_position) + 64'(prod_r)
                                    : 64'(y_position) + 64'(prod_r);

  // division operands: value * 1000 over step (or step << 16 for wheels)
  always_comb begin
    case (dsel)
      DIV_LIN:  nv = 64'(ds);
      DIV_TURN: nv = 64'($signed(dth));
      DIV_LEFT: nv = 64'(wl_p);
      default:  nv = 64'(wr_p);
    endcase
  end

  assign nk      = (nv <<< 10) - (nv <<< 4) - (nv <<< 3);
  assign nneg    = nv[63];
  assign nmag    = nneg ? 64'(-nk) : 64'(nk);
  assign dden    = ((dsel == DIV_LEFT) || (dsel == DIV_RIGHT)) ? {step, 16'h0}
                                                               : {16'h0, step};
  assign dnum    = nmag + 64'(dden >> 1);
  assign d_start = (state == ST_DV_GO);
  assign dres    = nneg ? -$signed(dquot) : $signed(dquot);

  ddo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (d_start),
    .num   (dnum),
    .den   (dden),
    .done  (d_done),
    .quot  (dquot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tick_to_radian <= 32'd6588397;
      radius_q16     <= 16'd2163;
      x_position     <= '0;
      y_position     <= '0;
      heading_angle  <= '0;
      previous_yaw   <= '0;
      res_valid      <= 1'b0;
      dsel           <= DIV_LIN;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ddo_pkg::REG_TICK_TO_RADIAN: tick_to_radian <= cfg_data;
          ddo_pkg::REG_RADIUS:         radius_q16     <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            lt   <= $signed(s_tdata[15:0]);
            rt   <= $signed(s_tdata[31:16]);
            qw   <= $signed(s_tdata[47:32]);
            qx   <= $signed(s_tdata[63:48]);
            qy   <= $signed(s_tdata[79:64]);
            qz   <= $signed(s_tdata[95:80]);
            step <= s_tdata[111:96];
            lin_speed <= '0;
            turn_rate <= '0;
            lw_speed  <= '0;
            rw_speed  <= '0;
            if (s_tuser) begin
              x_position    <= '0;
              y_position    <= '0;
              heading_angle <= '0;
              res_valid     <= 1'b1;
              state         <= ST_OUT;
            end else if (s_tdata[111:96] == 16'h0) begin
              res_valid <= 1'b0;
              state     <= ST_OUT;
            end else begin
              state <= ST_Q0;
            end
          end
        end
        ST_Q0: begin acc_y <= m_p[33:0];         state <= ST_Q1; end
        ST_Q1: begin acc_y <= acc_y + m_p[33:0]; state <= ST_Q2; end
        ST_Q2: begin
          acc_x <= (34'sd1 <<< 27) - m_p[33:0];
          state <= ST_Q3;
        end
        ST_Q3: begin acc_x <= acc_x - m_p[33:0]; state <= ST_VEC_GO; end
        ST_VEC_GO: begin
          if (vec_zero) begin
            yaw   <= '0;
            state <= ST_T0;
          end else begin
            state <= ST_VEC_W;
          end
        end
        ST_VEC_W: begin
          if (c_done) begin
            yaw   <= 16'((cz + 32'h8000) >> 16);
            state <= ST_T0;
          end
        end
        ST_T0: begin acc_m <= m_p[47:0]; state <= ST_T1; end
        ST_T1: begin acc_d <= m_p[63:0]; state <= ST_T2; end
        ST_T2: begin
          acc_d <= acc_d + {m_p[39:0], 24'h0};
          state <= ST_ROT_GO;
        end
        ST_ROT_GO: begin
          ds    <= sum[16] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
          dth   <= dth_c;
          flip  <= flip_c;
          state <= ST_ROT_W;
        end
        ST_ROT_W: begin
          if (c_done) begin
            c_val <= flip ? -cx[31:0] : cx[31:0];
            s_val <= flip ? -cy[31:0] : cy[31:0];
            state <= ST_PX;
          end
        end
        ST_PX: begin prod <= m_p[65:0]; state <= ST_PY; end
        ST_PY: begin
          x_position <= ddo_pkg::sat32(pos_sum);
          prod       <= m_p[65:0];
          state      <= ST_PH;
        end
        ST_PH: begin
          y_position    <= ddo_pkg::sat32(pos_sum);
          heading_angle <= heading_angle + dth;
          previous_yaw  <= yaw;
          state         <= ST_WL;
        end
        ST_WL: begin wl_p <= m_p[48:0]; state <= ST_WR; end
        ST_WR: begin
          wr_p  <= m_p[48:0];
          dsel  <= DIV_LIN;
          state <= ST_DV_GO;
        end
        ST_DV_GO: state <= ST_DV_W;
        ST_DV_W: begin
          if (d_done) begin
            case (dsel)
              DIV_LIN:  lin_speed <= ddo_pkg::sat32(dres);
              DIV_TURN: turn_rate <= ddo_pkg::sat32(dres);
              DIV_LEFT: lw_speed  <= ddo_pkg::sat32(dres);
              default:  rw_speed  <= ddo_pkg::sat32(dres);
            endcase
            if (dsel == DIV_RIGHT) begin
              res_valid <= 1'b1;
              state     <= ST_OUT;
            end else begin
              dsel  <= dsel + 2'd1;
              state <= ST_DV_GO;
            end
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready stayed high after an input transfer");

  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
    else $error("block did not return to idle after an output transfer");

  a_zero_step_speeds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[207:80] == '0))
    else $error("speeds not zero on a skipped update");

endmodule

/* verif/tb_diff_drive_odometry.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry
// Streams odometry updates and pose resets through the block and checks each
// result against a bit-accurate predictor, under random gaps, stalls and a
// few register settings.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry;

  localparam int STEPS     = 16;
  localparam int IDLE_WAIT = 400;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 580;
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_RESET  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] lt, rt, qw, qx, qy, qz;
    logic [15:0]       step;
  } upd_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] px, py;
    logic [15:0]        hd;
    logic signed [31:0] lin, turn, lw, rw;
  } pose_t;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [111:0] s_tdata;
  logic m_tvalid, m_tready, m_tuser;
  logic [207:0] m_tdata;
  logic cfg_we, cfg_index;
  logic [31:0] cfg_data;

  diff_drive_odometry #(.CORDIC_STEPS(STEPS)) u_top (.*);

  // predictor state
  logic [31:0] k_tick;
  logic [15:0] k_radius;
  logic signed [31:0] x_pos, y_pos;
  logic [15:0] head_ang, last_yaw;

  upd_t  pending_q[$];
  pose_t pose_q[$];
  int    errors;
  int    hold_off;
  int    burst_len, gap_len;
  bit    in_took;
  longint idle_cycles;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint div_half_away(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [15:0] yaw_from(longint y, longint x);
    logic [31:0] z;
    longint xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = shr(x, i); ys = shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += ddo_pkg::atan_of(ddo_pkg::TAB_IDX_W'(i));
      end else begin
        x -= ys; y += xs; z -= ddo_pkg::atan_of(ddo_pkg::TAB_IDX_W'(i));
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
    bit flip;
    longint x, y, z, xs, ys;
    logic [31:0] t;
    flip = 0; x = 652032874; y = 0;
    t = ang + 32'h40000000;
    if (t[31]) begin
      ang = ang + 32'h80000000; flip = 1;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < STEPS; i++) begin
      xs = shr(x, i); ys = shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ddo_pkg::atan_of(ddo_pkg::TAB_IDX_W'(i)));
      end else begin
        x += ys; y -= xs; z += longint'(ddo_pkg::atan_of(ddo_pkg::TAB_IDX_W'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_pose(input upd_t u);
    pose_t r;
    longint lt, rt, qw, qx, qy, qz, sum, ds, c, s, dth, stp;
    logic [63:0] mag;
    logic [15:0] yaw, dy;
    logic [31:0] mid;
    r = '0;
    if (u.kind == KIND_RESET) begin
      x_pos = 0; y_pos = 0; head_ang = 0;
      r.ok = 1;
    end else if (u.step == 0) begin
      r.px = x_pos; r.py = y_pos; r.hd = head_ang;
    end else begin
      lt = u.lt; rt = u.rt; qw = u.qw; qx = u.qx; qy = u.qy; qz = u.qz;
      stp = u.step;
      sum = lt + rt;
      mag = 64'(k_tick) * 64'(k_radius) * 64'(sum < 0 ? -sum : sum);
      ds = longint'((mag + 64'h100000000) >> 33);
      if (sum < 0) ds = -ds;
      yaw = yaw_from(qx * qy + qw * qz, (64'sd1 <<< 27) - qy * qy - qz * qz);
      dy = yaw - last_yaw;
      dth = longint'($signed(dy));
      mid = {head_ang, 16'h0} + 32'(dth * 32768);
      rotate_unit(mid, c, s);
      x_pos = clip32(longint'(x_pos) + shr(ds * c + (64'sd1 <<< 29), 30));
      y_pos = clip32(longint'(y_pos) + shr(ds * s + (64'sd1 <<< 29), 30));
      head_ang = head_ang + dy;
      last_yaw = yaw;
      r.ok = 1; r.px = x_pos; r.py = y_pos; r.hd = head_ang;
      r.lin  = clip32(div_half_away(ds * 1000, stp));
      r.turn = clip32(div_half_away(dth * 1000, stp));
      r.lw   = clip32(div_half_away(longint'(k_tick) * lt * 1000, stp << 16));
      r.rw   = clip32(div_half_away(longint'(k_tick) * rt * 1000, stp << 16));
    end
    pose_q.push_back(r);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // input transfer seen at the rising edge
  always @(posedge clk) begin
    in_took <= !rst && s_tvalid && s_tready;
  end

  // driver: bursts and gaps, falling-edge updates
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (in_took) begin
        predict_pose(pending_q.pop_front());
      end
      if (s_tvalid && !in_took) begin
        // hold the offered item
      end else if (gap_len > 0) begin
        gap_len--;
        s_tvalid <= 0;
      end else if (pending_q.size() > 0) begin
        s_tvalid <= 1;
        s_tuser  <= pending_q[0].kind;
        s_tdata  <= {pending_q[0].step, pending_q[0].qz, pending_q[0].qy,
                     pending_q[0].qx, pending_q[0].qw, pending_q[0].rt,
                     pending_q[0].lt};
        if (burst_len > 0) begin
          burst_len--;
        end else begin
          burst_len = $urandom_range(0, 8);
          gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
        end
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // receiver stall pattern, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_t e, a;
    if (!rst && m_tvalid && m_tready) begin
      a = {m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[79:64],
           m_tdata[111:80], m_tdata[143:112], m_tdata[175:144],
           m_tdata[207:176]};
      if (pose_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result exp none got %h", $time, a);
      end else begin
        e = pose_q.pop_front();
        if (e.ok !== a.ok) begin errors++;
          $display("%0t valid_res exp %0d got %0d", $time, e.ok, a.ok); end
        if (e.px !== a.px) begin errors++;
          $display("%0t pos_x exp %0d got %0d", $time, e.px, a.px); end
        if (e.py !== a.py) begin errors++;
          $display("%0t pos_y exp %0d got %0d", $time, e.py, a.py); end
        if (e.hd !== a.hd) begin errors++;
          $display("%0t heading exp %0d got %0d", $time, e.hd, a.hd); end
        if (e.lin !== a.lin) begin errors++;
          $display("%0t linear_speed exp %0d got %0d", $time, e.lin, a.lin); end
        if (e.turn !== a.turn) begin errors++;
          $display("%0t turn_rate exp %0d got %0d", $time, e.turn, a.turn); end
        if (e.lw !== a.lw) begin errors++;
          $display("%0t left_wheel_speed exp %0d got %0d", $time, e.lw, a.lw); end
        if (e.rw !== a.rw) begin errors++;
          $display("%0t right_wheel_speed exp %0d got %0d", $time, e.rw, a.rw); end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic upd_t rand_update(bit wellformed);
    upd_t u;
    int mag;
    u.kind = KIND_UPDATE;
    u.lt = 16'($urandom); u.rt = 16'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      u.lt = 16'($signed($urandom_range(0, 400)) - 200);
      u.rt = 16'($signed($urandom_range(0, 400)) - 200);
    end
    // mostly unit-ish quaternions: yaw-only or random components
    if (wellformed) begin
      u.qw = 16'($signed($urandom_range(0, 32768)) - 16384);
      u.qx = 16'($signed($urandom_range(0, 2000)) - 1000);
      u.qy = 16'($signed($urandom_range(0, 2000)) - 1000);
      mag = 16384 - ((u.qw < 0) ? -u.qw : u.qw);
      u.qz = 16'($signed($urandom_range(0, 2 * mag)) - mag);
    end else begin
      u.qw = 16'($signed($urandom_range(0, 32768)) - 16384);
      u.qx = 16'($signed($urandom_range(0, 32768)) - 16384);
      u.qy = 16'($signed($urandom_range(0, 32768)) - 16384);
      u.qz = 16'($signed($urandom_range(0, 32768)) - 16384);
    end
    case ($urandom_range(0, 9))
      0: u.step = 16'd0;
      1: u.step = 16'($urandom);
      2: u.step = 16'd1;
      default: u.step = 16'($urandom_range(1, 200));
    endcase
    return u;
  endfunction

  function automatic upd_t mk(logic k, int lt, int rt, int qw, int qx, int qy,
                              int qz, int st);
    upd_t u;
    u.kind = k; u.lt = 16'(lt); u.rt = 16'(rt); u.qw = 16'(qw); u.qx = 16'(qx);
    u.qy = 16'(qy); u.qz = 16'(qz); u.step = 16'(st);
    return u;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_tvalid || pose_q.size() > 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == ddo_pkg::REG_TICK_TO_RADIAN) k_tick = val; else k_radius = val[15:0];
  endtask

  initial begin
    upd_t u;
    rst = 1; s_tvalid = 0; s_tuser = 0; s_tdata = '0; m_tready = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    errors = 0; hold_off = 0; burst_len = 0; gap_len = 0;
    k_tick = 32'd6588397; k_radius = 16'd2163;
    x_pos = 0; y_pos = 0; head_ang = 0; last_yaw = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, both kinds, zero step, degenerate quaternion, yaw wrap
    pending_q.push_back(mk(KIND_UPDATE, 100, 100, 16384, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_UPDATE, 0, 0, 0, 0, 0, 0, 10));
    pending_q.push_back(mk(KIND_UPDATE, 32767, 32767, 11585, 0, 0, 11585, 1));
    pending_q.push_back(mk(KIND_UPDATE, -32768, -32768, 0, 0, 0, 16384, 1));
    pending_q.push_back(mk(KIND_UPDATE, 32767, -32768, -16384, 0, 0, 200, 65535));
    pending_q.push_back(mk(KIND_UPDATE, -1, 1, 200, 0, 0, -16384, 7));
    pending_q.push_back(mk(KIND_UPDATE, 5, 9, 16384, 16384, 16384, 16384, 3));
    pending_q.push_back(mk(KIND_UPDATE, 5, 9, -16384, -16384, -16384, -16384, 3));
    pending_q.push_back(mk(KIND_UPDATE, 5, 9, 0, 16384, -16384, 0, 65535));
    pending_q.push_back(mk(KIND_RESET, -1, -1, -1, -1, -1, -1, 16'hffff));
    pending_q.push_back(mk(KIND_UPDATE, 300, 290, 11585, 0, 0, -11585, 50));
    pending_q.push_back(mk(KIND_RESET, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 60; i++)
      pending_q.push_back(mk(KIND_UPDATE, 32767, 32767, 16384, 0, 0, 0, 1));
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin write_reg(ddo_pkg::REG_TICK_TO_RADIAN, 32'hffffffff);
                 write_reg(ddo_pkg::REG_RADIUS, 32'hffff); end
        2: begin write_reg(ddo_pkg::REG_TICK_TO_RADIAN, 32'd0);
                 write_reg(ddo_pkg::REG_RADIUS, 32'd1); end
        3: begin write_reg(ddo_pkg::REG_TICK_TO_RADIAN, $urandom);
                 write_reg(ddo_pkg::REG_RADIUS, $urandom_range(1, 65535)); end
        4: begin write_reg(ddo_pkg::REG_TICK_TO_RADIAN, 32'd6588397);
                 write_reg(ddo_pkg::REG_RADIUS, 32'd2163); end
        default: ;
      endcase
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        if ($urandom_range(0, 40) == 0) begin
          u = rand_update(0); u.kind = KIND_RESET;
        end else begin
          u = rand_update($urandom_range(0, 4) != 0);
        end
        pending_q.push_back(u);
      end
      if (ph == 2) begin
        hold_off = 3000;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
